[sv/stes_pkg.sv]
// ----------------------------------------------------------------------------
// stes_pkg
// Shared types and codes for the score table with exchange sort.
// ----------------------------------------------------------------------------
package stes_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int SCORE_W          = 16;
	localparam int TAG_W            = 16;
	localparam int RANK_W           = 4;

	// One table entry as held in the entry memory
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	// Input opcodes
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_LIST   = 1'b1;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_APPENDED = 2'd0,
		KIND_REFUSED  = 2'd1,
		KIND_LISTED   = 2'd2,
		KIND_EMPTY    = 2'd3
	} kind_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_GET_I,
		S_CMP,
		S_WB_I,
		S_LIST
	} state_t;

endpackage

[sv/stes_ram.sv]
// ----------------------------------------------------------------------------
// stes_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stes_ram import stes_pkg::*; #(
	parameter int DEPTH  = DEFAULT_CAPACITY,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_s1;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

[sv/score_table_exchange_sort.sv]
// ----------------------------------------------------------------------------
// score_table_exchange_sort
// Score table with append, in-place descending exchange sort and listing.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat (opcode, score, entry_tag) is taken at a rising edge with
//   start high and busy low. Results leave on kind, score_out, tag_out, rank
//   and last, marked by valid for exactly one cycle; the receiver cannot
//   stall, so every result is taken in the cycle it is shown.
//   Append: one result (appended or refused when full) the cycle after the
//   beat; busy stays low, so appends may be issued every cycle.
//   List of an empty table: one result the cycle after the beat.
//   List of n entries: the sort walks the entry memory through its single
//   read port, one compare per cycle. Pass i loads entry i, makes n-1-i
//   compares against the entries above it and writes entry i back. After
//   the sort, n list reads follow, one per cycle; the last read's data passes
//   the memory read register and the result register before it is shown.
//   busy is high throughout and drops in the cycle the last result is shown.
//   Reset clears the entry count and the controller; the entry memory is
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module score_table_exchange_sort import stes_pkg::*; #(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [SCORE_W-1:0] score,
	input  logic [TAG_W-1:0]   entry_tag,
	output logic               valid,
	output logic [1:0]         kind,
	output logic [SCORE_W-1:0] score_out,
	output logic [TAG_W-1:0]   tag_out,
	output logic [RANK_W-1:0]  rank,
	output logic               last
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     i_q, j_q, k_q;
	entry_t            cur_q;
	logic              pend_s1, last_s1;
	logic [IW-1:0]     rank_s1;
	logic              valid_q, last_q;
	kind_t             kind_q;
	logic [SCORE_W-1:0] score_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RANK_W-1:0] rank_q;

	logic              ram_we, ram_re;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;

	logic              accept;
	logic              swap;
	logic [CW-1:0]     j_next, i_next2, k_next;
	logic [IW+RANK_W-1:0] rank_ext;

	assign accept  = start && !busy;
	assign swap    = ram_rdata.score > cur_q.score;
	assign j_next  = CW'(j_q) + CW'(1);
	assign i_next2 = CW'(i_q) + CW'(2);
	assign k_next  = CW'(k_q) + CW'(1);
	assign rank_ext = {{RANK_W{1'b0}}, rank_s1};

	stes_ram #(
		.DEPTH (CAPACITY),
		.ADDR_W(IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Hold the controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_APPEND) begin
						if (count_q < CAP_C) begin
							ram_we    = 1'b1;
							ram_waddr = count_q[IW-1:0];
							ram_wdata = '{score: score, tag: entry_tag};
						end
					end else if (count_q >= CW'(2)) begin
						ram_re  = 1'b1;
						state_d = S_GET_I;
					end else if (count_q == CW'(1)) begin
						state_d = S_LIST;
					end
				end
			end
			S_GET_I: begin
				ram_re    = 1'b1;
				ram_raddr = i_q + IW'(1);
				state_d   = S_CMP;
			end
			S_CMP: begin
				if (swap) begin
					ram_we    = 1'b1;
					ram_waddr = j_q;
				end
				if (j_next < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = j_next[IW-1:0];
				end else begin
					state_d = S_WB_I;
				end
			end
			S_WB_I: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				if (i_next2 < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = i_q + IW'(1);
					state_d   = S_GET_I;
				end else begin
					state_d = S_LIST;
				end
			end
			S_LIST: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				if (k_next == count_q) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance count and loop indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_LIST);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_APPEND && count_q < CAP_C) begin
							count_q <= count_q + CW'(1);
						end
						i_q <= '0;
						k_q <= '0;
					end
				end
				S_GET_I: begin
					j_q <= i_q + IW'(1);
				end
				S_CMP: begin
					j_q <= j_next[IW-1:0];
				end
				S_WB_I: begin
					i_q <= i_q + IW'(1);
				end
				S_LIST: begin
					k_q <= k_next[IW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the entry under pass i; take the larger one on a swap
	always_ff @(posedge clk) begin
		if (state_q == S_GET_I || (state_q == S_CMP && swap)) begin
			cur_q <= ram_rdata;
		end
		if (state_q == S_LIST) begin
			rank_s1 <= k_q;
			last_s1 <= (k_next == count_q);
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= pend_s1 ||
				(accept && (opcode == OP_APPEND || count_q == '0));
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			kind_q  <= KIND_LISTED;
			score_q <= ram_rdata.score;
			tag_q   <= ram_rdata.tag;
			rank_q  <= rank_ext[RANK_W-1:0];
			last_q  <= last_s1;
		end else if (accept) begin
			if (opcode == OP_APPEND) begin
				kind_q <= (count_q < CAP_C) ? KIND_APPENDED : KIND_REFUSED;
			end else begin
				kind_q <= KIND_EMPTY;
			end
			score_q <= '0;
			tag_q   <= '0;
			rank_q  <= '0;
			last_q  <= 1'b1;
		end
	end

	assign busy      = (state_q != S_IDLE) || pend_s1;
	assign valid     = valid_q;
	assign kind      = kind_q;
	assign score_out = score_q;
	assign tag_out   = tag_q;
	assign rank      = rank_q;
	assign last      = last_q;

	// The table never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// Compares always look above the entry under pass i
	a_cmp_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> j_q > i_q)
		else $error("compare index not above pass index");

	// A write and a read never hit the same entry in one cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> ram_waddr != ram_raddr)
		else $error("read and write on the same entry");

	// Listing of an empty table gives one final empty result
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LIST && count_q == '0) |=>
		(valid_q && kind_q == KIND_EMPTY && last_q))
		else $error("empty list result missing");

	// Listed entries leave back to back until the last
	a_list_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_LISTED && !last_q) |=>
		(valid_q && kind_q == KIND_LISTED))
		else $error("gap in listed results");

endmodule
